@@ hw/rtl/hnc_pkg.sv @@
package hnc_pkg;

  localparam int BIN_BITS  = 16;
  localparam int DVD_W     = 33;
  localparam int DVS_W     = BIN_BITS + 1;
  localparam int NORM_W    = 40;
  localparam int CHI_W     = 24;
  localparam int SCORE_W   = 48;
  localparam int ROOT_W    = 20;
  localparam int GAIN_W    = 16;
  localparam int BPH_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPH  = 1'd1;

  localparam logic [3:0] EXP_TERMS = 4'd14;
  localparam logic [1:0] EXP_SQUARINGS_LAST = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CHI_WAIT,
    ST_ACC,
    ST_ROOT_WAIT,
    ST_SCORE,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_EXP_CHK,
    ST_TERM_MUL,
    ST_TERM_WAIT,
    ST_CAP,
    ST_SQUARE,
    ST_FIN
  } state_t;

endpackage

@@ hw/rtl/histogram_normchi_likelihood_core.sv @@
// Chi-square histogram distance likelihood core.
// Input channel (in_valid/in_ready) takes one beat per bin: measured_bin,
// predicted_bin and last_bin. Output channel (out_valid/out_ready) gives one
// beat per particle, on the bin flagged last_bin: likelihood_value and
// distance_score.
// Config writes (cfg_write/cfg_index/cfg_data): index 0 gain, 1 bins per
// sub-histogram; write only while idle.
// Each bin runs one division on the shared 33-step radix-2 divider.
// A bin closing a sub-histogram adds the 21-step square root and the
// score multiply. The last bin adds the exponential series, whose 14
// term divisions reuse the same divider (the series is skipped when the
// exponent reaches 12.0 and the output is zero).
// in_ready is high only while the sequencer is idle. The result sits in an
// output register; the next particle proceeds while it waits, and only its
// own final write stalls until out_ready drains the earlier beat.
// Reset (rst, synchronous) clears the sums and the bin counter, drops any pending
// result, and sets gain to 1.0 and 8 bins per sub-histogram.
module histogram_normchi_likelihood_core #(
  parameter int MAX_BINS_PER_HISTOGRAM = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hnc_pkg::GAIN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   measured_bin,
  input  logic [15:0]                   predicted_bin,
  input  logic                          last_bin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   likelihood_value,
  output logic [47:0]                   distance_score
);
  import hnc_pkg::*;

  localparam int SZ_W = $clog2(MAX_BINS_PER_HISTOGRAM + 1);
  localparam int CW   = (SZ_W > BPH_W) ? SZ_W : BPH_W;

  state_t state, state_next;

  logic [GAIN_W-1:0]   gain;
  logic [BPH_W-1:0]    bph;
  logic [CW-1:0]       bin_count;
  logic [NORM_W-1:0]   norm_sum;
  logic [CHI_W-1:0]    chi_sum;
  logic [SCORE_W-1:0]  score_sum;

  logic [BIN_BITS-1:0] m, p;
  logic                last;
  logic [2*BIN_BITS-1:0] d2;
  logic                close_hist;

  logic [ROOT_W+CHI_W-1:0] prod;
  logic [39:0]         gp_lo;
  logic [39:0]         e;
  logic [31:0]         r;
  logic [32:0]         term;
  logic [33:0]         y;
  logic [31:0]         ys;
  logic [3:0]          n;
  logic [1:0]          k;

  logic                div_start, div_done;
  logic                sqrt_start, sqrt_done;
  logic [DVD_W-1:0]    div_dvd, div_q;
  logic [DVS_W-1:0]    div_dvs;
  logic [ROOT_W-1:0]   root;

  logic [CW-1:0]       size;
  logic [BIN_BITS-1:0] d;
  logic [2*BIN_BITS-1:0] d_sq;
  logic [NORM_W:0]     norm_add;
  logic [NORM_W-1:0]   norm_sat;
  logic [DVD_W:0]      chi_add;
  logic [SCORE_W:0]    score_add;
  logic [63:0]         gfull;
  logic [64:0]         tprod;
  logic [63:0]         ysq;
  logic [16:0]         lik_r;
  logic                out_free;

  always_comb begin
    if (bph == '0) size = CW'(1);
    else if (CW'(bph) > CW'(MAX_BINS_PER_HISTOGRAM)) size = CW'(MAX_BINS_PER_HISTOGRAM);
    else size = CW'(bph);
    d         = (m >= p) ? m - p : p - m;
    d_sq      = d * d;
    norm_add  = {1'b0, norm_sum} + (NORM_W+1)'(d2);
    norm_sat  = norm_add[NORM_W] ? {NORM_W{1'b1}} : norm_add[NORM_W-1:0];
    chi_add   = (DVD_W+1)'(chi_sum) + (DVD_W+1)'(div_q);
    score_add = {1'b0, score_sum} + (SCORE_W+1)'(prod);
    gfull     = {(GAIN_W + 24)'(gain) * score_sum[47:24], 24'd0} + 64'(gp_lo);
    tprod     = term * r;
    ysq       = 64'(ys) * 64'(ys) + (64'd1 << 31);
    lik_r     = 17'(ys[31:16]) + 17'(ys[15]);
    out_free  = !out_valid || out_ready;
  end

  assign div_dvd = (state == ST_DIFF) ? DVD_W'(d_sq) : tprod[64:32];
  assign div_dvs = (state == ST_DIFF) ? DVS_W'(m) + DVS_W'(p) + DVS_W'(1) : DVS_W'(n);

  hnc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  hnc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (norm_sat),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_DIFF;
      ST_DIFF:      state_next = ST_CHI_WAIT;
      ST_CHI_WAIT:  if (div_done) state_next = ST_ACC;
      ST_ACC:       if (close_hist) state_next = ST_ROOT_WAIT;
                    else if (last) state_next = ST_GAIN_LO;
                    else state_next = ST_IDLE;
      ST_ROOT_WAIT: if (sqrt_done) state_next = ST_SCORE;
      ST_SCORE:     state_next = last ? ST_GAIN_LO : ST_IDLE;
      ST_GAIN_LO:   state_next = ST_GAIN_HI;
      ST_GAIN_HI:   state_next = ST_EXP_CHK;
      ST_EXP_CHK:   state_next = (e >= (40'd12 << 16)) ? ST_FIN : ST_TERM_MUL;
      ST_TERM_MUL:  state_next = ST_TERM_WAIT;
      ST_TERM_WAIT: if (div_done) state_next = (n == EXP_TERMS) ? ST_CAP : ST_TERM_MUL;
      ST_CAP:       state_next = ST_SQUARE;
      ST_SQUARE:    if (k == EXP_SQUARINGS_LAST) state_next = ST_FIN;
      ST_FIN:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    div_start  = (state == ST_DIFF) || (state == ST_TERM_MUL);
    sqrt_start = 1'b0;
    if (state == ST_ACC) sqrt_start = close_hist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gain      <= GAIN_W'(256);
      bph       <= BPH_W'(8);
      bin_count <= '0;
      norm_sum  <= '0;
      chi_sum   <= '0;
      score_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN: gain <= cfg_data;
          REG_BPH:  bph  <= cfg_data[BPH_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_FIN && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_ACC: begin
          norm_sum <= norm_sat;
          chi_sum  <= (chi_add > (DVD_W+1)'({CHI_W{1'b1}})) ? {CHI_W{1'b1}}
                                                           : chi_add[CHI_W-1:0];
          if (close_hist) bin_count <= '0;
          else bin_count <= bin_count + 1'b1;
        end
        ST_SCORE: begin
          score_sum <= score_add[SCORE_W] ? {SCORE_W{1'b1}} : score_add[SCORE_W-1:0];
          norm_sum  <= '0;
          chi_sum   <= '0;
        end
        ST_FIN: begin
          if (out_free) begin
            bin_count <= '0;
            norm_sum  <= '0;
            chi_sum   <= '0;
            score_sum <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        m    <= measured_bin[BIN_BITS-1:0];
        p    <= predicted_bin[BIN_BITS-1:0];
        last <= last_bin;
      end
      ST_DIFF: d2 <= d_sq;
      ST_CHI_WAIT: close_hist <= (bin_count + 1'b1) >= size;
      ST_ROOT_WAIT: prod <= root * chi_sum;
      ST_GAIN_LO: gp_lo <= gain * score_sum[23:0];
      ST_GAIN_HI: e <= gfull[63:24];
      ST_EXP_CHK: begin
        r    <= {e[19:0], 12'd0};
        y    <= 34'd1 << 32;
        term <= 33'd1 << 32;
        n    <= 4'd1;
        ys   <= '0;
      end
      ST_TERM_WAIT: begin
        if (div_done) begin
          term <= div_q;
          y    <= n[0] ? y - 34'(div_q) : y + 34'(div_q);
          n    <= n + 1'b1;
        end
      end
      ST_CAP: begin
        ys <= (y > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : y[31:0];
        k  <= '0;
      end
      ST_SQUARE: begin
        ys <= ysq[63:32];
        k  <= k + 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          likelihood_value <= lik_r[16] ? 16'hFFFF : lik_r[15:0];
          distance_score   <= score_sum;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/hnc_div.sv @@
module hnc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hnc_pkg::DVD_W-1:0] dividend,
  input  logic [hnc_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [hnc_pkg::DVD_W-1:0] quotient
);
  import hnc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem;
  logic [DVS_W:0]   rem_sh;
  logic             take;

  always_comb begin
    rem_sh = {rem[DVS_W-1:0], quotient[DVD_W-1]};
    take   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[DVD_W-2:0], take};
    end
  end

endmodule

@@ hw/rtl/hnc_sqrt.sv @@
module hnc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hnc_pkg::NORM_W-1:0] radicand,
  output logic                       done,
  output logic [hnc_pkg::ROOT_W-1:0] root
);
  import hnc_pkg::*;

  localparam int W = NORM_W + 2;

  logic         busy;
  logic [W-1:0] v;
  logic [W-1:0] res;
  logic [W-1:0] bitv;
  logic [W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv == W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= W'(radicand);
      res  <= '0;
      bitv <= W'(1) << NORM_W;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule
